// ===== hdl/scc_pkg.sv =====
// Shared types, constants and register indexes of the shot clock controller.
// No dependencies; imported by every other file of the block.
package scc_pkg;

  localparam int TIMER_BITS          = 16;
  localparam int DISCOVER_WAIT_TICKS = 2000;
  localparam int DISCOVER_TRIES      = 4;
  localparam int MAX_SECONDS         = 99;

  localparam int SEC_BITS       = 7;
  localparam int WAIT_BITS      = 12;
  localparam int TRIES_BITS     = 3;
  localparam int INTERVAL_BITS  = 16;
  localparam int BRIGHT_BITS    = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [SEC_BITS-1:0]   seconds_t;

  localparam timer_t   TIMER_MAX   = '1;
  localparam seconds_t SECONDS_MAX = SEC_BITS'(MAX_SECONDS);

  typedef enum logic [2:0] {
    K_TICK,
    K_PLAY_PAUSE,
    K_RESET_VALUE,
    K_RESET_DEFAULT,
    K_ADJUST,
    K_LINK_TIMEOUT
  } kind_t;

  typedef enum logic [1:0] {
    PH_DISC,
    PH_WAIT,
    PH_RUN
  } phase_t;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DEFAULT_TIME   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT_INTERVAL = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REFRESH        = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BRIGHTNESS     = 2'd3;

  localparam seconds_t                 RST_DEFAULT_TIME = 7'd30;
  localparam logic [INTERVAL_BITS-1:0] RST_COUNT_INTERVAL = 16'd1000;
  localparam logic [INTERVAL_BITS-1:0] RST_REFRESH = 16'd500;
  localparam logic [BRIGHT_BITS-1:0]   RST_BRIGHTNESS = 8'd8;

  typedef struct packed {
    seconds_t                 default_reset_time;
    logic [INTERVAL_BITS-1:0] count_interval;
    logic [INTERVAL_BITS-1:0] paused_refresh_interval;
    logic [BRIGHT_BITS-1:0]   brightness;
  } scc_cfg_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic              play_after_reset;
    logic signed [7:0] reset_value;
    logic signed [7:0] adjust_amount;
  } scc_cmd_t;

  typedef struct packed {
    logic                   display_update;
    seconds_t               display_seconds;
    logic [BRIGHT_BITS-1:0] display_brightness;
    logic                   is_running;
    logic                   honk;
    logic                   discover_request;
    logic [1:0]             mode;
  } scc_status_t;

endpackage

// ===== hdl/scc_if.sv =====
// Valid/ready channels of the shot clock controller: command beats in,
// status beats out. Depends on scc_pkg.
interface scc_cmd_if;
  import scc_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic              play_after_reset;
  logic signed [7:0] reset_value;
  logic signed [7:0] adjust_amount;

  modport source (output valid, kind, play_after_reset, reset_value, adjust_amount,
                  input ready);
  modport sink   (input valid, kind, play_after_reset, reset_value, adjust_amount,
                  output ready);
endinterface

interface scc_status_if;
  import scc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   display_update;
  seconds_t               display_seconds;
  logic [BRIGHT_BITS-1:0] display_brightness;
  logic                   is_running;
  logic                   honk;
  logic                   discover_request;
  logic [1:0]             mode;

  modport source (output valid, display_update, display_seconds, display_brightness,
                  is_running, honk, discover_request, mode, input ready);
  modport sink   (input valid, display_update, display_seconds, display_brightness,
                  is_running, honk, discover_request, mode, output ready);
endinterface

// ===== hdl/scc_regs.sv =====
// Configuration register file of the shot clock controller.
// Depends on scc_pkg.
module scc_regs
  import scc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output scc_cfg_t                  cfg
);

  seconds_t default_clamped;

  always_comb begin
    priority if (cfg_data[SEC_BITS-1:0] == '0) begin
      default_clamped = seconds_t'(1);
    end else if (cfg_data[SEC_BITS-1:0] > SECONDS_MAX) begin
      default_clamped = SECONDS_MAX;
    end else begin
      default_clamped = cfg_data[SEC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.default_reset_time      <= RST_DEFAULT_TIME;
      cfg.count_interval          <= RST_COUNT_INTERVAL;
      cfg.paused_refresh_interval <= RST_REFRESH;
      cfg.brightness              <= RST_BRIGHTNESS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEFAULT_TIME:   cfg.default_reset_time      <= default_clamped;
        REG_COUNT_INTERVAL: cfg.count_interval          <= cfg_data[INTERVAL_BITS-1:0];
        REG_REFRESH:        cfg.paused_refresh_interval <= cfg_data[INTERVAL_BITS-1:0];
        REG_BRIGHTNESS:     cfg.brightness              <= cfg_data[BRIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/scc_core.sv =====
// Controller core: input register, clock state with its next-state logic,
// and the status output register. Depends on scc_pkg and scc_if.
module scc_core
  import scc_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  scc_cfg_t       cfg,
  scc_cmd_if.sink        cmd,
  scc_status_if.source   status
);

  // input stage
  logic     s1_valid;
  scc_cmd_t s1_cmd;
  logic     advance;

  // output stage
  logic        out_valid;
  scc_status_t out_data;

  // clock state
  phase_t                phase, phase_next;
  logic [TRIES_BITS-1:0] tries, tries_next;
  logic [WAIT_BITS-1:0]  wait_ticks, wait_ticks_next;
  timer_t                count_ticks, count_ticks_next;
  timer_t                refresh_ticks, refresh_ticks_next;
  seconds_t              remaining, remaining_next;
  logic                  running, running_next;

  kind_t             kind;
  timer_t            count_inc, refresh_inc;
  logic              wait_done, count_due, refresh_due;
  logic              upd, honk, disc;
  seconds_t          reset_clamped;
  logic signed [8:0] adj_sum;
  seconds_t          adj_clamped;

  assign advance   = s1_valid && (!out_valid || status.ready);
  assign cmd.ready = !s1_valid || advance;
  assign kind      = kind_t'(s1_cmd.kind);

  assign count_inc   = (count_ticks == TIMER_MAX) ? count_ticks : count_ticks + 1'b1;
  assign refresh_inc = (refresh_ticks == TIMER_MAX) ? refresh_ticks : refresh_ticks + 1'b1;
  assign wait_done   = wait_ticks >= WAIT_BITS'(DISCOVER_WAIT_TICKS);
  assign count_due   = running && (remaining != '0) &&
                       (32'(count_inc) >= 32'(cfg.count_interval));
  assign refresh_due = !running && (32'(refresh_inc) >= 32'(cfg.paused_refresh_interval));

  always_comb begin
    priority if (s1_cmd.reset_value < 8'sd1) begin
      reset_clamped = seconds_t'(1);
    end else if (s1_cmd.reset_value > 8'sd99) begin
      reset_clamped = SECONDS_MAX;
    end else begin
      reset_clamped = s1_cmd.reset_value[SEC_BITS-1:0];
    end
  end

  assign adj_sum = $signed({2'b00, remaining}) + 9'(s1_cmd.adjust_amount);

  always_comb begin
    priority if (adj_sum < 9'sd0) begin
      adj_clamped = '0;
    end else if (adj_sum > 9'sd99) begin
      adj_clamped = SECONDS_MAX;
    end else begin
      adj_clamped = adj_sum[SEC_BITS-1:0];
    end
  end

  // phase sequencing
  always_comb begin
    phase_next = phase;
    unique case (kind)
      K_TICK: begin
        unique case (phase)
          PH_DISC: phase_next = PH_WAIT;
          PH_WAIT: if (wait_done) begin
            phase_next = (tries < TRIES_BITS'(DISCOVER_TRIES)) ? PH_DISC : PH_RUN;
          end
          PH_RUN: ;
          default: ;
        endcase
      end
      K_LINK_TIMEOUT: if (phase == PH_WAIT) begin
        phase_next = PH_RUN;
      end
      default: ;
    endcase
  end

  // result flags
  always_comb begin
    upd  = 1'b0;
    honk = 1'b0;
    disc = 1'b0;
    unique case (kind)
      K_TICK: begin
        disc = (phase == PH_DISC);
        if (phase == PH_RUN) begin
          upd  = count_due || refresh_due;
          honk = count_due && (remaining == seconds_t'(1));
        end
      end
      K_PLAY_PAUSE, K_RESET_VALUE, K_RESET_DEFAULT: upd = 1'b1;
      K_ADJUST: upd = !running;
      default: ;
    endcase
  end

  // counters and clock value
  always_comb begin
    tries_next         = tries;
    wait_ticks_next    = wait_ticks;
    count_ticks_next   = count_ticks;
    refresh_ticks_next = refresh_ticks;
    remaining_next     = remaining;
    running_next       = running;
    unique case (kind)
      K_TICK: begin
        count_ticks_next   = count_inc;
        refresh_ticks_next = refresh_inc;
        unique case (phase)
          PH_DISC: begin
            if (tries != '1) tries_next = tries + 1'b1;
            wait_ticks_next = '0;
          end
          PH_WAIT: if (!wait_done) begin
            wait_ticks_next = wait_ticks + 1'b1;
          end
          PH_RUN: begin
            if (running) begin
              if (remaining == '0) begin
                running_next = 1'b0;
              end else if (count_due) begin
                remaining_next     = remaining - 1'b1;
                running_next       = (remaining != seconds_t'(1));
                count_ticks_next   = '0;
                refresh_ticks_next = '0;
              end
            end else if (refresh_due) begin
              refresh_ticks_next = '0;
            end
          end
          default: ;
        endcase
      end
      K_PLAY_PAUSE: running_next = !running;
      K_RESET_VALUE, K_RESET_DEFAULT: begin
        remaining_next     = (kind == K_RESET_VALUE) ? reset_clamped : cfg.default_reset_time;
        running_next       = s1_cmd.play_after_reset;
        count_ticks_next   = '0;
        refresh_ticks_next = '0;
      end
      K_ADJUST: if (!running) begin
        remaining_next     = adj_clamped;
        count_ticks_next   = '0;
        refresh_ticks_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
    if (cmd.ready && cmd.valid) begin
      s1_cmd <= '{kind: cmd.kind, play_after_reset: cmd.play_after_reset,
                  reset_value: cmd.reset_value, adjust_amount: cmd.adjust_amount};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DISC;
      tries         <= '0;
      wait_ticks    <= '0;
      count_ticks   <= '0;
      refresh_ticks <= '0;
      remaining     <= RST_DEFAULT_TIME;
      running       <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      tries         <= tries_next;
      wait_ticks    <= wait_ticks_next;
      count_ticks   <= count_ticks_next;
      refresh_ticks <= refresh_ticks_next;
      remaining     <= remaining_next;
      running       <= running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (status.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data <= '{display_update: upd, display_seconds: remaining_next,
                    display_brightness: cfg.brightness, is_running: running_next,
                    honk: honk, discover_request: disc, mode: phase_next};
    end
  end

  assign status.valid              = out_valid;
  assign status.display_update     = out_data.display_update;
  assign status.display_seconds    = out_data.display_seconds;
  assign status.display_brightness = out_data.display_brightness;
  assign status.is_running         = out_data.is_running;
  assign status.honk               = out_data.honk;
  assign status.discover_request   = out_data.discover_request;
  assign status.mode               = out_data.mode;

  a_honk_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.honk |->
      out_data.display_update && !out_data.is_running && out_data.display_seconds == '0)
    else $error("honk without a stop at zero");

  a_disc_enters_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.discover_request |-> out_data.mode == PH_WAIT)
    else $error("discovery request outside the wait phase");

  a_seconds_range: assert property (@(posedge clk) disable iff (rst)
    remaining <= SECONDS_MAX)
    else $error("remaining seconds out of range");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_cmd))
    else $error("stalled command beat lost");

  a_state_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(remaining) && $stable(running) && $stable(phase))
    else $error("clock state changed without a beat");

endmodule

// ===== hdl/shot_clock_countdown_controller_unit.sv =====
// Top level of the shot clock countdown controller.
// Depends on scc_pkg, scc_if, scc_regs and scc_core.
//
// Usage:
//   cmd carries one beat per event: a millisecond tick or a command
//   (play/pause, reset to value, reset to default, adjust, link timeout).
//   status returns exactly one beat per command beat, in order: the
//   display update strobe, remaining seconds, brightness, running flag,
//   honk, discovery request and phase.
//   Configuration is written through cfg_we/cfg_index/cfg_data while no
//   beat is in flight; default_reset_time is clamped to 1..99 on write.
// Timing:
//   A command beat passes through the input register, then the status
//   register, on its way to status. One beat is taken per cycle while
//   status is not stalled; the state logic between them is combinational.
// Reset (rst, synchronous): phase discover, timers and tries cleared,
//   clock stopped at 30 s, registers to their defaults, both stages empty.
// Stall: while status.ready is low the status register holds; the input
//   register takes one more beat, then cmd.ready drops until the sink
//   takes the waiting beat.
module shot_clock_countdown_controller_unit
  import scc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  scc_cmd_if.sink                   cmd,
  scc_status_if.source              status,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  scc_cfg_t cfg;

  scc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  scc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status)
  );

endmodule
